// ----- src/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 4;
	localparam int PEND_W  = 3;
	localparam int COUNT_W = 16;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register map: register i sits at byte address 8*i.
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LENGTH,
		REG_REPLACEMENT_BYTES,
		REG_REPLACEMENT_LENGTH
	} reg_index_t;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               last_of_run;
		logic [COUNT_W-1:0] replacements_done;
	} out_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] pattern_bytes;
		logic [LEN_W-1:0]  pattern_length;
		logic [DATA_W-1:0] replacement_bytes;
		logic [LEN_W-1:0]  replacement_length;
	} cfg_t;

	// Control that goes with a freshly built run of results.
	typedef struct packed {
		logic               load;
		logic               status;
		logic [COUNT_W-1:0] count_value;
	} run_ctl_t;

endpackage

// ----- src/sfr_regs.sv -----
`timescale 1ns / 1ps

module sfr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]      paddr,
	input  logic [sfr_pkg::DATA_W-1:0]      pwdata,
	output logic [sfr_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output sfr_pkg::cfg_t                   cfg
);

	logic [sfr_pkg::DATA_W-1:0] pattern_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]  pattern_length_q;
	logic [sfr_pkg::DATA_W-1:0] replacement_bytes_q;
	logic [sfr_pkg::LEN_W-1:0]  replacement_length_q;
	logic                       wr_en;
	sfr_pkg::reg_index_t        idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = sfr_pkg::reg_index_t'(paddr[sfr_pkg::ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= sfr_pkg::LEN_W'(1);
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				sfr_pkg::REG_PATTERN_BYTES: begin
					pattern_bytes_q <= pwdata;
				end
				sfr_pkg::REG_PATTERN_LENGTH: begin
					pattern_length_q <= pwdata[sfr_pkg::LEN_W-1:0];
				end
				sfr_pkg::REG_REPLACEMENT_BYTES: begin
					replacement_bytes_q <= pwdata;
				end
				sfr_pkg::REG_REPLACEMENT_LENGTH: begin
					replacement_length_q <= pwdata[sfr_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			sfr_pkg::REG_PATTERN_BYTES:      prdata = pattern_bytes_q;
			sfr_pkg::REG_PATTERN_LENGTH:     prdata = {{(sfr_pkg::DATA_W-sfr_pkg::LEN_W){1'b0}},
				pattern_length_q};
			sfr_pkg::REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_q;
			sfr_pkg::REG_REPLACEMENT_LENGTH: prdata = {{(sfr_pkg::DATA_W-sfr_pkg::LEN_W){1'b0}},
				replacement_length_q};
			default:                         prdata = '0;
		endcase
	end

	assign cfg = '{
		pattern_bytes:      pattern_bytes_q,
		pattern_length:     pattern_length_q,
		replacement_bytes:  replacement_bytes_q,
		replacement_length: replacement_length_q
	};

endmodule

// ----- src/sfr_core.sv -----
`timescale 1ns / 1ps

module sfr_core #(
	parameter int PATTERN_MAX = 8,
	parameter int REPLACE_MAX = 8,
	parameter int RUN_MAX     = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  sfr_pkg::in_item_t                  in_item,
	input  sfr_pkg::cfg_t                      cfg,
	input  logic                               run_free,
	output sfr_pkg::run_ctl_t                  run_ctl,
	output logic [sfr_pkg::LEN_W-1:0]          run_count,
	output logic [RUN_MAX*sfr_pkg::BYTE_W-1:0] run_bytes
);

	localparam int BW = sfr_pkg::BYTE_W;
	localparam int LW = sfr_pkg::LEN_W;

	// Input register.
	logic              valid_s1;
	sfr_pkg::in_item_t item_s1;

	// Stream state. The last window entry is only ever a scratch copy.
	logic [BW-1:0]                win_q [PATTERN_MAX];
	logic [sfr_pkg::PEND_W-1:0]   pend_q;
	logic [sfr_pkg::COUNT_W-1:0]  count_q;

	logic                         in_take;
	logic                         process;
	logic [BW-1:0]                cand [PATTERN_MAX];
	logic [BW-1:0]                new_win [PATTERN_MAX];
	logic [LW-1:0]                plen;
	logic [LW-1:0]                rlen;
	logic [LW-1:0]                total;
	logic [LW-1:0]                base;
	logic [LW-1:0]                drop;
	logic                         full;
	logic                         hit;
	logic                         win_wr;
	logic [sfr_pkg::PEND_W-1:0]   pend_d;
	logic [sfr_pkg::COUNT_W-1:0]  count_d;
	logic [sfr_pkg::COUNT_W-1:0]  count_inc;

	assign in_stall = valid_s1 & ~run_free;
	assign in_take  = in_valid & ~in_stall;
	assign process  = valid_s1 & run_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// Effective lengths after clamping.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			plen = LW'(1);
		end else if (cfg.pattern_length > LW'(PATTERN_MAX)) begin
			plen = LW'(PATTERN_MAX);
		end else begin
			plen = cfg.pattern_length;
		end
		if (cfg.replacement_length > LW'(REPLACE_MAX)) begin
			rlen = LW'(REPLACE_MAX);
		end else begin
			rlen = cfg.replacement_length;
		end
	end

	assign total     = {1'b0, pend_q} + LW'(1);
	assign full      = total >= plen;
	assign base      = total - plen;
	assign drop      = base + LW'(1);
	assign count_inc = (count_q == sfr_pkg::COUNT_MAX) ? count_q
		: count_q + sfr_pkg::COUNT_W'(1);

	// Pending bytes followed by the new byte.
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			cand[i] = (LW'(i) < {1'b0, pend_q}) ? win_q[i] : item_s1.in_byte;
		end
	end

	// Compare the tail of the candidate window against the pattern.
	always_comb begin
		logic [BW-1:0] sel;
		hit = full;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			sel = '0;
			for (int j = 0; j < PATTERN_MAX; j++) begin
				if (LW'(j) == base + LW'(i)) begin
					sel = cand[j];
				end
			end
			if (LW'(i) < plen && sel != cfg.pattern_bytes[BW*i +: BW]) begin
				hit = 1'b0;
			end
		end
	end

	// Build the next window, pending count, counter and result run.
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			new_win[i] = cand[i];
		end
		win_wr    = 1'b0;
		pend_d    = pend_q;
		count_d   = count_q;
		run_count = '0;
		run_bytes = '0;
		run_ctl   = '{load: process, status: 1'b0, count_value: count_q};

		if (item_s1.end_of_stream) begin
			// Flush pending bytes; the status entry carries a zero byte.
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (LW'(i) < {1'b0, pend_q}) begin
					run_bytes[BW*i +: BW] = win_q[i];
				end
			end
			run_count          = total;
			run_ctl.status     = 1'b1;
			pend_d             = '0;
			count_d            = '0;
		end else if (hit) begin
			for (int i = 0; i < REPLACE_MAX; i++) begin
				run_bytes[BW*i +: BW] = cfg.replacement_bytes[BW*i +: BW];
			end
			run_count           = rlen;
			run_ctl.count_value = count_inc;
			count_d             = count_inc;
			pend_d              = '0;
		end else if (full) begin
			// Window overflows: emit the oldest bytes, keep the newest plen-1.
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (LW'(i) < drop) begin
					run_bytes[BW*i +: BW] = cand[i];
				end
				new_win[i] = '0;
				for (int j = 0; j < PATTERN_MAX; j++) begin
					if (LW'(j) == drop + LW'(i)) begin
						new_win[i] = cand[j];
					end
				end
			end
			run_count = drop;
			win_wr    = 1'b1;
			pend_d    = sfr_pkg::PEND_W'(plen - LW'(1));
		end else begin
			win_wr = 1'b1;
			pend_d = total[sfr_pkg::PEND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			count_q <= '0;
		end else if (process) begin
			pend_q  <= pend_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (process && win_wr) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= new_win[i];
			end
		end
	end

endmodule

// ----- src/sfr_emit.sv -----
`timescale 1ns / 1ps

module sfr_emit #(
	parameter int RUN_MAX = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfr_pkg::run_ctl_t                  run_ctl,
	input  logic [sfr_pkg::LEN_W-1:0]          run_count,
	input  logic [RUN_MAX*sfr_pkg::BYTE_W-1:0] run_bytes,
	output logic                               run_free,
	output logic                               out_valid,
	input  logic                               out_stall,
	output sfr_pkg::out_item_t                 out_item
);

	localparam int BW = sfr_pkg::BYTE_W;

	logic [BW-1:0]                bytes_q [RUN_MAX];
	logic [sfr_pkg::LEN_W-1:0]    left_q;
	logic                         status_q;
	logic [sfr_pkg::COUNT_W-1:0]  value_q;
	logic                         last;
	logic                         out_take;
	logic                         load;

	assign out_valid = left_q != '0;
	assign last      = left_q == sfr_pkg::LEN_W'(1);
	assign out_take  = out_valid & ~out_stall;
	assign run_free  = ~out_valid | (out_take & last);
	assign load      = run_ctl.load & (run_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= run_count;
		end else if (out_take) begin
			left_q <= left_q - sfr_pkg::LEN_W'(1);
		end
	end

	// The head entry is always at index 0; each delivered result shifts the run.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RUN_MAX; i++) begin
				bytes_q[i] <= run_bytes[BW*i +: BW];
			end
			status_q <= run_ctl.status;
			value_q  <= run_ctl.count_value;
		end else if (out_take) begin
			for (int i = 0; i < RUN_MAX - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

	assign out_item = '{
		out_byte:          bytes_q[0],
		byte_valid:        ~(status_q & last),
		last_of_run:       last,
		replacements_done: value_q
	};

endmodule

// ----- src/stream_find_and_replace_unit.sv -----
`timescale 1ns / 1ps

// Streaming literal find-and-replace. Bytes arrive one item at a time and leave with
// every leftmost, non-overlapping occurrence of the configured pattern (1 to 8 bytes)
// replaced by the configured replacement (0 to 8 bytes, zero deletes the match). Up to
// pattern_length-1 recent bytes are held back because they may still start a match.
// An item with end_of_stream set flushes those bytes and then produces a status item
// (byte_valid low) carrying the saturating count of replacements; the count and the
// held bytes then clear so the next stream starts fresh. Each input item passes an
// input register and is resolved combinationally into a run of 0 to 8 result items
// held in an output buffer, which delivers one result item per cycle while out_stall
// is low; last_of_run marks the final result of each input item. A new input item is
// taken every cycle as long as each item produces at most one result and out_stall
// stays low, so a plain byte stream runs at one item per cycle. An item that produces
// several results holds off the next item until the output buffer hands out its
// last result (for example a full-length replacement or an end-of-stream flush). The
// pattern and replacement registers sit on the APB-style port at byte addresses 0, 8,
// 16 and 24 and should only be written while the block is idle.

module stream_find_and_replace_unit #(
	parameter int PATTERN_MAX = 8,
	parameter int REPLACE_MAX = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,

	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
	output logic [sfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,

	// Input item channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sfr_pkg::in_item_t           in_item,

	// Result item channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output sfr_pkg::out_item_t          out_item
);

	// The longest run is a full replacement or a flush of a full window plus status.
	localparam int RUN_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

	sfr_pkg::cfg_t                      cfg;
	sfr_pkg::run_ctl_t                  run_ctl;
	logic [sfr_pkg::LEN_W-1:0]          run_count;
	logic [RUN_MAX*sfr_pkg::BYTE_W-1:0] run_bytes;
	logic                               run_free;

	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Match logic and stream state: decides what each item emits.
	sfr_core #(
		.PATTERN_MAX (PATTERN_MAX),
		.REPLACE_MAX (REPLACE_MAX),
		.RUN_MAX     (RUN_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg       (cfg),
		.run_free  (run_free),
		.run_ctl   (run_ctl),
		.run_count (run_count),
		.run_bytes (run_bytes)
	);

	// Output buffer: hands out the run one result per cycle while out_stall is low.
	sfr_emit #(
		.RUN_MAX (RUN_MAX)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_ctl   (run_ctl),
		.run_count (run_count),
		.run_bytes (run_bytes),
		.run_free  (run_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- verif/stream_find_and_replace_unit_test.sv -----
`timescale 1ns / 1ps

module stream_find_and_replace_unit_test;

	import sfr_pkg::*;

	localparam int PATTERN_MAX     = 8;
	localparam int REPLACE_MAX     = 8;
	localparam int RESET_CYCLES    = 6;
	// This settle time is ample for an item that produced no result to finish
	// before the rules are rewritten.
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int REPORT_LIMIT    = 10;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;

	// Shadow of the rewrite rules as last written over the configuration port.
	logic [DATA_W-1:0]   pattern_word    = '0;
	logic [LEN_W-1:0]    pattern_len_reg = 4'd1;
	logic [DATA_W-1:0]   replace_word    = '0;
	logic [LEN_W-1:0]    replace_len_reg = '0;

	// Predictor state: bytes held back because they may still begin a match,
	// and the number of replacements made in the current stream.
	logic [BYTE_W-1:0]   held_bytes [0:PATTERN_MAX-2];
	int unsigned         held_count    = 0;
	logic [COUNT_W-1:0]  replace_tally = '0;

	// Result items of the rewritten stream that have not arrived yet, oldest first.
	out_item_t           rewrite_queue [$];

	int unsigned         mismatch_count = 0;
	int unsigned         cycle_count    = 0;

	// Sender burst shaping and receiver stall pattern, tuned per test.
	int unsigned         burst_left   = 0;
	int unsigned         gap_max      = 5;
	int unsigned         stall_pct    = 30;
	bit                  hold_off_req = 1'b0;

	stream_find_and_replace_unit #(
		.PATTERN_MAX (PATTERN_MAX),
		.REPLACE_MAX (REPLACE_MAX)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A pattern length of zero behaves as one, and anything past the window
	// size behaves as the full window.
	function automatic int unsigned pattern_span();
		if (pattern_len_reg == 0)
			return 1;
		if (pattern_len_reg > PATTERN_MAX)
			return PATTERN_MAX;
		return pattern_len_reg;
	endfunction

	function automatic int unsigned replace_span();
		if (replace_len_reg > REPLACE_MAX)
			return REPLACE_MAX;
		return replace_len_reg;
	endfunction

	function automatic void queue_output(input logic [BYTE_W-1:0] b, input logic is_byte,
			input logic last);
		out_item_t r;
		r.out_byte          = b;
		r.byte_valid        = is_byte;
		r.last_of_run       = last;
		r.replacements_done = replace_tally;
		rewrite_queue.push_back(r);
	endfunction

	function automatic void rewrite_item(input in_item_t item);
		logic [BYTE_W-1:0] window [0:PATTERN_MAX-1];
		int unsigned plen, rlen, total, drop, i;
		bit hit;
		plen = pattern_span();
		rlen = replace_span();

		// End of stream: flush whatever is held, then the status item. The
		// stream's state clears so that the next one starts fresh.
		if (item.end_of_stream) begin
			for (i = 0; i < held_count; i++)
				queue_output(held_bytes[i], 1'b1, 1'b0);
			queue_output('0, 1'b0, 1'b1);
			held_count    = 0;
			replace_tally = '0;
			return;
		end

		for (i = 0; i < held_count; i++)
			window[i] = held_bytes[i];
		window[held_count] = item.in_byte;
		total = held_count + 1;

		// The newest plen bytes are compared against the pattern.
		hit = (total >= plen);
		for (i = 0; hit && i < plen; i++)
			if (window[total - plen + i] != pattern_word[8*i +: 8])
				hit = 1'b0;

		if (hit) begin
			// A match drops every held byte, even ones left over from a
			// longer pattern, and emits the replacement.
			if (replace_tally != COUNT_MAX)
				replace_tally++;
			for (i = 0; i < rlen; i++)
				queue_output(replace_word[8*i +: 8], 1'b1, i == rlen - 1);
			held_count = 0;
		end else if (total > plen - 1) begin
			// The window overflows: the oldest bytes leave, several at once
			// when the pattern was shortened while bytes were held.
			drop = total - (plen - 1);
			for (i = 0; i < drop; i++)
				queue_output(window[i], 1'b1, i == drop - 1);
			for (i = 0; i < plen - 1; i++)
				held_bytes[i] = window[drop + i];
			held_count = plen - 1;
		end else begin
			held_bytes[held_count] = item.in_byte;
			held_count = total;
		end
	endfunction

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------

	function automatic void flag_result(input string what, input out_item_t want,
			input out_item_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t %s: expected byte %02h valid %b last %b count %0d,",
				$realtime, what, want.out_byte, want.byte_valid, want.last_of_run,
				want.replacements_done,
				" got byte %02h valid %b last %b count %0d",
				got.out_byte, got.byte_valid, got.last_of_run, got.replacements_done);
	endfunction

	// A result item is taken at an edge where out_valid is high and out_stall is
	// low. Both are read here before any update scheduled at this same edge.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rewrite_queue.size() == 0) begin
				flag_result("unexpected result item", '0, out_item);
			end else begin
				want = rewrite_queue.pop_front();
				if (out_item.out_byte !== want.out_byte
						|| out_item.byte_valid !== want.byte_valid
						|| out_item.last_of_run !== want.last_of_run
						|| out_item.replacements_done !== want.replacements_done)
					flag_result("result item mismatch", want, out_item);
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall runs of random length, and a long hold-off on request
	// ------------------------------------------------------------------

	initial begin : result_receiver
		int unsigned run_len;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				run_len = $urandom_range(1, 8);
				out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
				repeat (run_len - 1) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration port and sender
	// ------------------------------------------------------------------

	// Setup phase, then access phase; the register takes the value at the edge
	// where pready is seen high during the access phase.
	task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES:      pattern_word    = value;
			REG_PATTERN_LENGTH:     pattern_len_reg = value[LEN_W-1:0];
			REG_REPLACEMENT_BYTES:  replace_word    = value;
			REG_REPLACEMENT_LENGTH: replace_len_reg = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_rules(input logic [DATA_W-1:0] pat, input logic [LEN_W-1:0] plen,
			input logic [DATA_W-1:0] rep, input logic [LEN_W-1:0] rlen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_REPLACEMENT_BYTES, rep);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
	endtask

	// Packs text into a register word, first character in the low byte.
	function automatic logic [DATA_W-1:0] pack_text(input string s);
		logic [DATA_W-1:0] word;
		int unsigned i;
		word = '0;
		for (i = 0; i < s.len() && i < 8; i++)
			word[8*i +: 8] = s[i];
		return word;
	endfunction

	// Offers one item and returns at the edge where it is accepted. A new burst
	// may start with a gap; within a burst valid stays high from item to item.
	task automatic send_item(input in_item_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_item  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		rewrite_item(item);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		in_item_t item;
		item.in_byte       = b;
		item.end_of_stream = 1'b0;
		send_item(item);
	endtask

	// The byte of an end-of-stream item is ignored, so it carries noise.
	task automatic send_end(input logic [BYTE_W-1:0] b);
		in_item_t item;
		item.in_byte       = b;
		item.end_of_stream = 1'b1;
		send_item(item);
	endtask

	task automatic send_string(input string s);
		int unsigned i;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Stops offering items, waits for every result, then lets the block settle
	// so that an item that caused no result is finished too.
	task automatic wait_idle();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (rewrite_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly whole copies of the pattern, a quarter of them with one byte
	// broken, plus bytes from the pattern's alphabet, free noise and the
	// occasional end of stream.
	task automatic send_random_text(input int unsigned n_items);
		int unsigned sent, plen, pick, broken, k;
		logic [BYTE_W-1:0] b;
		sent = 0;
		plen = pattern_span();
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_end(8'($urandom_range(0, 255)));
				sent++;
			end else if (pick < 60) begin
				broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, plen - 1) : plen;
				for (k = 0; k < plen; k++) begin
					b = (k == broken) ? 8'($urandom_range(0, 255)) : pattern_word[8*k +: 8];
					send_byte(b);
				end
				sent += plen;
			end else if (pick < 80) begin
				k = $urandom_range(0, plen - 1);
				send_byte(pattern_word[8*k +: 8]);
				sent++;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Two-byte pattern with a longer replacement: a clean match, a match after
	// a false start, the byte extremes, a flush with a held byte and an end of
	// stream with nothing held.
	task automatic test_directed_rewrite();
		set_rules(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3);
		send_string("ab");
		send_string("aab");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_end(8'hA5);
		send_end(8'h00);
		wait_idle();
	endtask

	// A pattern length of zero acts as one, and a replacement length past the
	// maximum gives the full eight bytes.
	task automatic test_length_limits();
		set_rules(64'hFF, 4'd0, 64'h8877_6655_4433_2211, 4'd15);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_end(8'h5A);
		wait_idle();
	endtask

	// The pattern is shortened while bytes are held: first a match drops all of
	// them, then a miss releases the whole excess in one go.
	task automatic test_window_shrink();
		set_rules(pack_text("AB"), 4'd8, pack_text("#"), 4'd1);
		send_string("qrstA");
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 4'd2);
		send_byte("B");
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 4'd6);
		send_string("uvwxy");
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 4'd2);
		send_byte("z");
		send_end(8'h00);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while most items expand to
	// eight results, so the block fills and has to stall its input.
	task automatic test_output_hold_off();
		stall_pct = 0;
		set_rules(64'h3C, 4'd1, {$urandom, $urandom}, 4'd8);
		hold_off_req = 1'b1;
		repeat (40)
			send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h3C);
		send_end(8'h00);
		wait_idle();
		stall_pct = 30;
	endtask

	// Several rule sets in turn, most of them random. Streams are not always
	// ended before the rules change, so held bytes carry over into a new
	// pattern length. One phase runs with no gaps and no stalls at all, and one
	// pauses the sender halfway until everything has drained.
	task automatic test_random_streams();
		int unsigned phase;
		logic [LEN_W-1:0] plen, rlen;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_rules('1, 4'd8, '0, 4'd8);
				1: set_rules('0, 4'd15, '1, 4'd15);
				default: begin
					plen = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 4))
						: 4'($urandom_range(0, 15));
					rlen = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8))
						: 4'($urandom_range(0, 15));
					set_rules({$urandom, $urandom}, plen, {$urandom, $urandom}, rlen);
				end
			endcase
			gap_max   = (phase == 0) ? 0 : 5;
			stall_pct = (phase == 0) ? 0 : $urandom_range(10, 70);
			if (phase == 3) begin
				send_random_text(24);
				wait_idle();
				send_random_text(24);
			end else begin
				send_random_text(48);
			end
			if ($urandom_range(0, 1) == 0)
				send_end(8'($urandom_range(0, 255)));
			wait_idle();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_rewrite();
		test_length_limits();
		test_window_shrink();
		test_output_hold_off();
		test_random_streams();
		wait_idle();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
